// ----- src/gls_pkg.sv -----
// Shared constants, types and helper functions of the greedy level scheduler.
package gls_pkg;

  localparam int MAX_CELLS = 65536;
  localparam int MAX_FACES = 4;
  localparam int NB_FIELDS = 4;
  localparam int FACE_LIM  = (MAX_FACES < NB_FIELDS) ? MAX_FACES : NB_FIELDS;
  localparam int CELL_W    = 16;
  localparam int FACE_W    = 3;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CELL_W:0]   cell_ext_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [FACE_W-1:0] face_t;

  // One entry of the mark memory: set, and the cell that was being scheduled when it was set.
  typedef struct packed {
    logic  valid;
    cell_t writer;
  } mark_t;

  typedef struct packed {
    face_t                 face_count;
    cell_t [NB_FIELDS-1:0] nb;
  } item_t;

  typedef struct packed {
    cell_t level_start;
    logic  end_of_list;
  } result_t;

  // Up to two result words handed to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DECIDE,
    ST_WR1,
    ST_WR2,
    ST_WR3
  } eng_state_t;

  function automatic logic in_map(input cell_ext_t idx);
    return 32'(idx) < 32'(MAX_CELLS);
  endfunction

  function automatic addr_t to_addr(input cell_ext_t idx);
    return ADDR_W'(idx);
  endfunction

endpackage

// ----- src/gls_if.sv -----
// Handshake interfaces of the scheduler: cell words in, level words out, configuration writes.
interface gls_item_if;
  import gls_pkg::*;
  logic  valid;
  logic  ready;
  face_t face_count;
  cell_t neighbor_0;
  cell_t neighbor_1;
  cell_t neighbor_2;
  cell_t neighbor_3;
  modport source (output valid, face_count, neighbor_0, neighbor_1, neighbor_2, neighbor_3,
                  input ready);
  modport sink (input valid, face_count, neighbor_0, neighbor_1, neighbor_2, neighbor_3,
                output ready);
endinterface

interface gls_result_if;
  import gls_pkg::*;
  logic  valid;
  logic  ready;
  cell_t level_start;
  logic  end_of_list;
  modport source (output valid, level_start, end_of_list, input ready);
  modport sink (input valid, level_start, end_of_list, output ready);
endinterface

interface gls_cfg_if;
  import gls_pkg::*;
  logic  valid;
  logic  ready;
  cell_t num_cells;
  modport source (output valid, num_cells, input ready);
  modport sink (input valid, num_cells, output ready);
endinterface

// ----- src/gls_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module gls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/gls_engine.sv -----
// Scheduling engine: holding register, mark memory sequencer and level decision.
module gls_engine (
  input  logic           clk,
  input  logic           rst,
  input  gls_pkg::cell_t num_cells,
  input  logic           fifo_room,
  gls_item_if.sink       items,
  output gls_pkg::push_t push
);
  import gls_pkg::*;

  eng_state_t            state, state_next;
  logic                  hold_valid;
  item_t                 hold_item;
  cell_t                 cur_cell, cur_cell_next;
  cell_t                 level_start, level_start_next;
  cell_t                 max_written, max_written_next;
  addr_t                 sweep_addr, sweep_addr_next;
  addr_t                 sweep_end, sweep_end_next;
  cell_t                 wk_cell;
  cell_t [NB_FIELDS-1:0] wk_nb;
  logic  [NB_FIELDS-1:0] wk_en;
  logic                  wk_hit;
  logic                  wk_rd_ok;
  logic  [NB_FIELDS-1:0] en;
  logic                  hit_any;
  logic                  rd_ok;
  logic                  take;
  logic                  start;
  logic                  is_last;
  logic                  need_sweep;
  logic                  marked;
  cell_ext_t             cell1;
  cell_ext_t             wk_cell1;
  face_t                 faces_sat;
  logic                  nb_we;
  cell_t                 nb_sel;
  cell_t                 nb_writer;
  logic                  ram_we;
  addr_t                 ram_waddr;
  addr_t                 ram_raddr;
  mark_t                 ram_wdata;
  mark_t                 ram_rdata;

  gls_ram #(
    .WIDTH ($bits(mark_t)),
    .DEPTH (MAX_CELLS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign start        = (state == ST_IDLE) && hold_valid && fifo_room;
  assign items.ready  = !hold_valid || start;
  assign take         = items.valid && items.ready;
  assign cell1        = cell_ext_t'(cur_cell) + cell_ext_t'(1);
  assign wk_cell1     = cell_ext_t'(wk_cell) + cell_ext_t'(1);
  assign is_last      = cell1 >= cell_ext_t'(num_cells);
  assign need_sweep   = max_written > cur_cell;
  assign rd_ok        = in_map(cell1);
  assign faces_sat    = (hold_item.face_count > FACE_W'(FACE_LIM)) ? FACE_W'(FACE_LIM)
                                                                   : hold_item.face_count;
  assign marked       = wk_hit ||
                        (wk_rd_ok && ram_rdata.valid && (ram_rdata.writer >= level_start));

  // Sort the active neighbours: the next cell is merged into the decision, earlier cells are
  // never read again in this pass, and only the rest need a memory write.
  always_comb begin
    en      = '0;
    hit_any = 1'b0;
    for (int f = 0; f < NB_FIELDS; f++) begin
      if ((FACE_W'(f) < faces_sat) && (hold_item.nb[f] < num_cells)) begin
        if (cell_ext_t'(hold_item.nb[f]) == cell1) begin
          hit_any = 1'b1;
        end else if ((hold_item.nb[f] > cur_cell) && in_map(cell_ext_t'(hold_item.nb[f]))) begin
          en[f] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        if (sweep_addr == sweep_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (!is_last) begin
            state_next = ST_DECIDE;
          end else if (need_sweep) begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_DECIDE: state_next = ST_WR1;
      ST_WR1:    state_next = ST_WR2;
      ST_WR2:    state_next = ST_WR3;
      ST_WR3:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = sweep_addr;
    ram_wdata        = '0;
    ram_raddr        = to_addr(cell1);
    push             = '0;
    nb_we            = 1'b0;
    nb_sel           = wk_nb[1];
    nb_writer        = wk_cell;
    cur_cell_next    = cur_cell;
    level_start_next = level_start;
    max_written_next = max_written;
    sweep_addr_next  = sweep_addr;
    sweep_end_next   = sweep_end;
    unique case (state)
      ST_SWEEP: begin
        ram_we          = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
      end
      ST_IDLE: begin
        if (start && is_last) begin
          if (cur_cell == '0) begin
            push.n  = 2'd2;
            push.r0 = '{level_start: '0, end_of_list: 1'b0};
            push.r1 = '{level_start: num_cells, end_of_list: 1'b1};
          end else begin
            push.n  = 2'd1;
            push.r0 = '{level_start: num_cells, end_of_list: 1'b1};
          end
          cur_cell_next    = '0;
          level_start_next = '0;
          max_written_next = '0;
          if (need_sweep) begin
            sweep_addr_next = to_addr(cell1);
            sweep_end_next  = to_addr(cell_ext_t'(max_written));
          end
        end else if (start) begin
          nb_we     = en[0];
          nb_sel    = hold_item.nb[0];
          nb_writer = cur_cell;
        end
      end
      ST_DECIDE: begin
        // The next cell's entry is spent once it has been read in this pass.
        ram_we    = wk_rd_ok;
        ram_waddr = to_addr(wk_cell1);
        if (wk_cell == '0) begin
          push.n  = marked ? 2'd2 : 2'd1;
          push.r0 = '{level_start: '0, end_of_list: 1'b0};
          push.r1 = '{level_start: wk_cell1[CELL_W-1:0], end_of_list: 1'b0};
        end else begin
          push.n  = marked ? 2'd1 : 2'd0;
          push.r0 = '{level_start: wk_cell1[CELL_W-1:0], end_of_list: 1'b0};
        end
        cur_cell_next = wk_cell1[CELL_W-1:0];
        if (marked) begin
          level_start_next = wk_cell1[CELL_W-1:0];
        end
      end
      ST_WR1: begin
        nb_we  = wk_en[1];
        nb_sel = wk_nb[1];
      end
      ST_WR2: begin
        nb_we  = wk_en[2];
        nb_sel = wk_nb[2];
      end
      ST_WR3: begin
        nb_we  = wk_en[3];
        nb_sel = wk_nb[3];
      end
      default: begin
      end
    endcase
    if (nb_we) begin
      ram_we    = 1'b1;
      ram_waddr = to_addr(cell_ext_t'(nb_sel));
      ram_wdata = '{valid: 1'b1, writer: nb_writer};
      if (nb_sel > max_written) begin
        max_written_next = nb_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      hold_valid  <= 1'b0;
      cur_cell    <= '0;
      level_start <= '0;
      max_written <= '0;
      sweep_addr  <= '0;
      sweep_end   <= ADDR_W'(MAX_CELLS - 1);
    end else begin
      state       <= state_next;
      cur_cell    <= cur_cell_next;
      level_start <= level_start_next;
      max_written <= max_written_next;
      sweep_addr  <= sweep_addr_next;
      sweep_end   <= sweep_end_next;
      if (take) begin
        hold_valid <= 1'b1;
      end else if (start) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item <= '{face_count: items.face_count,
                     nb: {items.neighbor_3, items.neighbor_2, items.neighbor_1, items.neighbor_0}};
    end
    if (start) begin
      wk_cell  <= cur_cell;
      wk_nb    <= hold_item.nb;
      wk_en    <= en;
      wk_hit   <= hit_any && rd_ok;
      wk_rd_ok <= rd_ok;
    end
  end

  a_level_behind_cell: assert property (@(posedge clk) disable iff (rst)
    level_start <= cur_cell)
    else $error("level start has moved past the current cell");

  a_push_timing: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> ((state == ST_DECIDE) || start))
    else $error("result words pushed outside a decision");

  a_two_only_cell_zero: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (((state == ST_DECIDE) && (wk_cell == '0)) ||
                          (start && (cur_cell == '0))))
    else $error("two result words for a cell other than cell zero");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (sweep_addr <= sweep_end))
    else $error("clearing sweep ran beyond its end address");

endmodule

// ----- src/gls_res_fifo.sv -----
// Small result queue that takes up to two words a cycle and hands out one.
module gls_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  gls_pkg::push_t push,
  output logic           room,
  gls_result_if.source   results
);
  import gls_pkg::*;

  result_t                entries [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_PTR_W:0]     count;
  logic                   pop;

  assign results.valid       = count != '0;
  assign results.level_start = entries[rd_ptr].level_start;
  assign results.end_of_list = entries[rd_ptr].end_of_list;
  assign pop                 = results.valid && results.ready;
  assign room                = count <= (RES_PTR_W + 1)'(RES_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[RES_PTR_W'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.n);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + (RES_PTR_W + 1)'(push.n) - (RES_PTR_W + 1)'(pop);
    end
  end

endmodule

// ----- src/greedy_level_schedule_top.sv -----
// Top level of the greedy level scheduler: configuration register, engine and result queue.
//
// Cells of a mesh are sent on the items channel in index order, one word per cell, carrying
// the face count and up to four neighbour indices. Each time a cell finds the next cell
// already marked, a word with that next index as the start of a new level leaves on the
// results channel; cell zero first gives a word for level zero, and the last cell gives the
// end marker (num_cells with end_of_list set) and rewinds the cell counter.
// The cfg channel writes num_cells; it is always ready and should only be used while no cell
// is in flight. Reset sets num_cells to one.
// The engine finishes each cell before it starts the next, since the mark memory has a single
// write port for up to four neighbour writes plus the one that retires the next cell's entry;
// the last cell needs no writes. A cell passes the holding register and the decide state (the
// idle state for the last cell), and its words the result queue, before they are on results.
// After reset the block sweeps the whole mark memory before it takes a cell from its holding
// register. If a pass ended early because num_cells was lowered, marks left beyond the last
// cell are swept in the same way, one entry a cycle.
// A stalled receiver lets words gather in the four-word result queue; once three are waiting
// the engine holds its next cell and the items channel takes at most one further word.
module greedy_level_schedule_top (
  input  logic         clk,
  input  logic         rst,
  gls_item_if.sink     items,
  gls_result_if.source results,
  gls_cfg_if.sink      cfg
);
  import gls_pkg::*;

  cell_t num_cells;
  push_t push;
  logic  fifo_room;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells <= CELL_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      num_cells <= cfg.num_cells;
    end
  end

  // The engine owns the mark memory and decides where each level starts.
  gls_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .num_cells (num_cells),
    .fifo_room (fifo_room),
    .items     (items),
    .push      (push)
  );

  // The queue decouples the engine from a slow receiver.
  gls_res_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (fifo_room),
    .results (results)
  );

endmodule
